@@ rtl/core/pwl_pkg.sv @@
// Shared types and constants for the piecewise linear curve core.
// Used by the front end, the back end, the top level and the checker.
package pwl_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_EVAL   = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam int XW = 17;
  localparam logic [XW-1:0] X_ONE = 17'h10000;
  localparam logic signed [31:0] Y_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Y_MIN = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         func;
    logic               x_ok;
    logic [XW-1:0]      qx;
    logic signed [31:0] y;
  } cmd_t;

endpackage

@@ rtl/core/pwl_front.sv @@
// Front end: classifies each incoming beat and holds it in a two-entry queue.
// Depends on pwl_pkg for the item and command types.
module pwl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pwl_pkg::in_item_t in_data,
  output logic              q_valid,
  output pwl_pkg::cmd_t     q_data,
  input  logic              q_pop
);
  import pwl_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.func = in_data.func;
    cls.y    = in_data.y_value;
    cls.x_ok = !in_data.x_value[31] && (in_data.x_value <= $signed({15'd0, X_ONE}));
    if (in_data.x_value[31]) begin
      cls.qx = '0;
    end else if (!cls.x_ok) begin
      cls.qx = X_ONE;
    end else begin
      cls.qx = in_data.x_value[XW-1:0];
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/core/pwl_back.sv @@
// Back end: breakpoint table, sorted insert, scan, divider and interpolation.
// Depends on pwl_pkg; takes commands from pwl_front and drives the result port.
module pwl_back #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pwl_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pwl_pkg::out_item_t out_data
);
  import pwl_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int SW = $clog2(FRAC_BITS);
  localparam int MW = XW + 32;
  localparam int PW = 33 + FRAC_BITS + 1;
  localparam int AW = PW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_SHR  = 4'd3;
  localparam logic [3:0] S_SHW  = 4'd4;
  localparam logic [3:0] S_INS  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [MW-1:0] mem [MAX_POINTS];
  logic [MW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  logic [3:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [XW-1:0]        prev_x_r, prev_x_nxt;
  logic signed [31:0]   prev_y_r, prev_y_nxt;
  logic signed [31:0]   cur_y_r, cur_y_nxt;
  logic [XW-1:0]        span_r, span_nxt;
  logic [XW-1:0]        rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [31:0]   res_y_r, res_y_nxt;
  logic [2:0]           res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic [XW-1:0]        ex;
  logic signed [31:0]   ey;
  logic                 last;
  logic [CW-1:0]        idx_m1;
  logic [XW:0]          r2;
  logic signed [32:0]   dy;
  logic signed [AW-1:0] sum;

  assign ex     = rd_data_r[MW-1:32];
  assign ey     = rd_data_r[31:0];
  assign last   = (idx_r == cnt_r - 1'b1);
  assign idx_m1 = idx_r - 1'b1;
  assign r2     = {rem_r, 1'b0};
  assign dy     = 33'(cur_y_r) - 33'(prev_y_r);
  assign sum    = AW'(prev_y_r) + AW'(prod_r >>> FRAC_BITS);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    cur_y_nxt  = cur_y_r;
    span_nxt   = span_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    prod_nxt   = prod_r;
    res_y_nxt  = res_y_r;
    res_st_nxt = res_st_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop      = 1'b0;
    rd_addr    = idx_r[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_r[IW-1:0];
    wr_data    = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_data;
          res_y_nxt  = '0;
          res_st_nxt = ST_OK;
          idx_nxt    = '0;
          pos_nxt    = '0;
          state_nxt  = S_OUT;
          case (q_data.func)
            FUNC_CLEAR: begin
              cnt_nxt = '0;
            end
            FUNC_INSERT: begin
              if (!q_data.x_ok) begin
                res_st_nxt = ST_RANGE;
              end else if (cnt_r == '0) begin
                state_nxt = S_INS;
              end else begin
                state_nxt = S_RD;
              end
            end
            FUNC_EVAL: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmd_r.func == FUNC_INSERT) begin
          if (ex == cmd_r.qx) begin
            res_st_nxt = ST_DUP;
            state_nxt  = S_OUT;
          end else if (cmd_r.qx < ex || last) begin
            pos_nxt = (cmd_r.qx < ex) ? idx_r : cnt_r;
            if (cnt_r >= CW'(MAX_POINTS)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else if (cmd_r.qx < ex) begin
              idx_nxt   = cnt_r;
              state_nxt = S_SHR;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (cmd_r.qx < ex) begin
            if (idx_r == '0) begin
              res_y_nxt = ey;
              state_nxt = S_OUT;
            end else begin
              cur_y_nxt = ey;
              span_nxt  = ex - prev_x_r;
              rem_nxt   = cmd_r.qx - prev_x_r;
              quo_nxt   = '0;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end else if (last) begin
            res_y_nxt = (cmd_r.qx == X_ONE) ? ey : '0;
            state_nxt = S_OUT;
          end else begin
            prev_x_nxt = ex;
            prev_y_nxt = ey;
            idx_nxt    = idx_r + 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      S_SHR: begin
        rd_addr   = idx_m1[IW-1:0];
        state_nxt = S_SHW;
      end
      S_SHW: begin
        wr_en   = 1'b1;
        idx_nxt = idx_m1;
        state_nxt = (idx_m1 == pos_r) ? S_INS : S_SHR;
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[IW-1:0];
        wr_data   = {cmd_r.qx, cmd_r.y};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (r2 >= {1'b0, span_r}) begin
          rem_nxt = XW'(r2 - {1'b0, span_r});
          quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = r2[XW-1:0];
          quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(FRAC_BITS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(dy * $signed({1'b0, quo_r}));
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (sum[AW-1:31] == '0 || (&sum[AW-1:31])) begin
          res_y_nxt = sum[31:0];
        end else begin
          res_y_nxt = sum[AW-1] ? Y_MIN : Y_MAX;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.result_y = res_y_r;
          out_nxt.status   = res_st_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    cmd_r    <= cmd_nxt;
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    cur_y_r  <= cur_y_nxt;
    span_r   <= span_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    step_r   <= step_nxt;
    prod_r   <= prod_nxt;
    res_y_r  <= res_y_nxt;
    res_st_r <= res_st_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ rtl/core/piecewise_linear_curve_core.sv @@
// Top level of the piecewise linear curve core: front end, queue and back end.
// Depends on pwl_pkg, pwl_front and pwl_back.
//
// Usage: each beat on the in_ channel carries a function (clear, insert,
// evaluate), an x and a y in signed Q16.16. Every beat yields exactly one
// beat on the out_ channel with the result y and a status code, in order.
// The front end classifies beats and holds up to two in its queue, so
// in_ready stays high while the back end works or the receiver stalls
// until two beats wait. The back end steps through the breakpoint memory
// one entry at a time, a read state and a compare state per entry (one
// read port, registered data). A clear or an out-of-range insert goes to
// the output state; an insert scans, shifts later entries up, writes the
// point; an evaluate scans, runs FRAC_BITS divider steps, multiplies, sums.
// The result waits in an output register until out_ready; meanwhile the
// back end holds its next result and the queue fills, then in_ready drops.
// After reset the table is empty; breakpoint contents are not cleared.
module piecewise_linear_curve_core #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pwl_pkg::out_item_t out_data
);
  import pwl_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  pwl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  pwl_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/pwl_checker.sv @@
// Port-level checks for the piecewise linear curve core, bound to the top.
// Depends on pwl_pkg for the result type and status codes.
module pwl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input pwl_pkg::out_item_t out_data
);
  import pwl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped before it was taken.");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_EMPTY)
    else $error("Status code out of range.");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_y == '0)
    else $error("Rejected item returned a non-zero result.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind piecewise_linear_curve_core pwl_checker u_pwl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
